FILE: sv/atf_pkg.sv
// shared types, constants and terminator tables for the at response and urc framer
`timescale 1ns / 1ps
`default_nettype none
package atf_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int FILL_W = ADDR_W + 1;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_URC_GAP = 1'd1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] GAP_RESET = 16'd50;
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	localparam logic [1:0] RES_WAIT = 2'd0;
	localparam logic [1:0] RES_OK = 2'd1;
	localparam logic [1:0] RES_ERROR = 2'd2;
	localparam logic [1:0] RES_TIMEOUT = 2'd3;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam int URC_MIN_LEN = 8;
	localparam logic [2:0] URC_MAX_SKIP = 3'd7;

	typedef enum logic [1:0] {
		ACT_BYTE  = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_START = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		MK_NONE  = 3'd0,
		MK_LINE  = 3'd1,
		MK_OK    = 3'd2,
		MK_ERROR = 3'd3,
		MK_SEND  = 3'd4
	} match_t;

	typedef enum logic [1:0] {
		NX_DONE = 2'd0,
		NX_SCAN = 2'd1,
		NX_READ = 2'd2
	} next_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic read_done;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		next_t next;
		logic  scan_done;
	} dp_stat_t;

	function automatic logic [3:0] term_len(input match_t k);
		case (k)
			MK_OK:    term_len = 4'd4;
			MK_ERROR: term_len = 4'd7;
			MK_SEND:  term_len = 4'd9;
			default:  term_len = 4'd0;
		endcase
	endfunction

	function automatic logic [7:0] term_char(input match_t k, input logic [3:0] p);
		logic [7:0] c;
		c = 8'h00;
		case (k)
			MK_OK: begin
				case (p)
					4'd0: c = 8'h4F;
					4'd1: c = 8'h4B;
					4'd2: c = CH_CR;
					4'd3: c = CH_LF;
					default: c = 8'h00;
				endcase
			end
			MK_ERROR: begin
				case (p)
					4'd0: c = 8'h45;
					4'd1: c = 8'h52;
					4'd2: c = 8'h52;
					4'd3: c = 8'h4F;
					4'd4: c = 8'h52;
					4'd5: c = CH_CR;
					4'd6: c = CH_LF;
					default: c = 8'h00;
				endcase
			end
			MK_SEND: begin
				case (p)
					4'd0: c = 8'h53;
					4'd1: c = 8'h45;
					4'd2: c = 8'h4E;
					4'd3: c = 8'h44;
					4'd4: c = 8'h20;
					4'd5: c = 8'h4F;
					4'd6: c = 8'h4B;
					4'd7: c = CH_CR;
					4'd8: c = CH_LF;
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		term_char = c;
	endfunction

	function automatic match_t first_kind(input logic [7:0] b);
		case (b)
			8'h4F:   first_kind = MK_OK;
			8'h45:   first_kind = MK_ERROR;
			8'h53:   first_kind = MK_SEND;
			default: first_kind = MK_NONE;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: sv/atf_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface atf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;
	logic [7:0] read_index;

	modport source (output valid, output action, output rx_byte, output read_index,
		input ready);
	modport sink (input valid, input action, input rx_byte, input read_index,
		output ready);
endinterface

interface atf_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [8:0] payload_length;
	logic [7:0] read_data;
	logic       urc_ready;
	logic [2:0] urc_start;
	logic [8:0] urc_length;
	logic       overflow;

	modport source (output valid, output status, output payload_length, output read_data,
		output urc_ready, output urc_start, output urc_length, output overflow, input ready);
	modport sink (input valid, input status, input payload_length, input read_data,
		input urc_ready, input urc_start, input urc_length, input overflow, output ready);
endinterface
`default_nettype wire

FILE: sv/atf_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module atf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: sv/atf_ctrl.sv
// sequencing state machine for the framer
`timescale 1ns / 1ps
`default_nettype none
module atf_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	output atf_pkg::dp_cmd_t   cmd,
	input  atf_pkg::dp_stat_t  stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RDWAIT,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.exec      = (state_q == S_EXEC);
		cmd.scan      = (state_q == S_SCAN);
		cmd.read_done = (state_q == S_RDWAIT);
		cmd.load      = (state_q == S_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (stat.next)
						atf_pkg::NX_SCAN: state_q <= S_SCAN;
						atf_pkg::NX_READ: state_q <= S_RDWAIT;
						default:          state_q <= S_HOLD;
					endcase
				end
				S_SCAN: begin
					if (stat.scan_done) begin
						state_q <= S_HOLD;
					end
				end
				S_RDWAIT: begin
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/atf_dp.sv
// framer datapath: state registers, matcher, buffer ram and result register
`timescale 1ns / 1ps
`default_nettype none
module atf_dp (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [atf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [atf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  atf_pkg::dp_cmd_t                   cmd,
	output atf_pkg::dp_stat_t                  stat,
	input  wire [1:0]                          action,
	input  wire [7:0]                          rx_byte,
	input  wire [7:0]                          read_index,
	output logic [1:0]                         status,
	output logic [8:0]                         payload_length,
	output logic [7:0]                         read_data,
	output logic                               urc_ready,
	output logic [2:0]                         urc_start,
	output logic [8:0]                         urc_length,
	output logic                               overflow
);

	localparam int AW = atf_pkg::ADDR_W;
	localparam int FW = atf_pkg::FILL_W;

	// item latch
	atf_pkg::action_t action_q;
	logic [7:0]       byte_q;
	logic [7:0]       idx_q;

	// framer state
	logic [FW-1:0]    fill_q, fill_n;
	logic             cmd_mode_q, cmd_mode_n;
	logic             echo_q, echo_n;
	atf_pkg::match_t  kind_q, kind_n, kind_c;
	logic [3:0]       pos_q, pos_n;
	logic [7:0]       prior_q, prior_n;
	logic [15:0]      elapsed_q, elapsed_n, elapsed_inc;
	logic [1:0]       result_q, result_n;
	logic [15:0]      timeout_q, gap_q;

	// per item results
	logic [2:0]       k_q, k_n;
	logic [7:0]       rdata_q, rdata_n;
	logic             ready_q, ready_n;
	logic [2:0]       ustart_q, ustart_n;
	logic [FW-1:0]    ulen_q, ulen_n;
	logic             ovf_q, ovf_n;

	logic             matched, do_store, full, idx_in_range;
	logic [3:0]       tlen;
	logic [FW-1:0]    k_ext;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [7:0]       ram_rdata;

	atf_ram #(
		.WIDTH (8),
		.DEPTH (atf_pkg::BUFFER_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (byte_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign full = fill_q >= FW'(atf_pkg::BUFFER_DEPTH);
	assign tlen = atf_pkg::term_len(kind_q);
	assign idx_in_range = {24'd0, idx_q} < 32'(atf_pkg::BUFFER_DEPTH);
	assign elapsed_inc = (elapsed_q == atf_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
	assign k_ext = FW'(k_q);

	always_comb begin
		fill_n     = fill_q;
		cmd_mode_n = cmd_mode_q;
		echo_n     = echo_q;
		kind_n     = kind_q;
		kind_c     = atf_pkg::MK_NONE;
		pos_n      = pos_q;
		prior_n    = prior_q;
		elapsed_n  = elapsed_q;
		result_n   = result_q;
		k_n        = k_q;
		rdata_n    = rdata_q;
		ready_n    = ready_q;
		ustart_n   = ustart_q;
		ulen_n     = ulen_q;
		ovf_n      = ovf_q;
		matched    = 1'b0;
		do_store   = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		stat.next      = atf_pkg::NX_DONE;
		stat.scan_done = 1'b0;

		if (cmd.exec) begin
			rdata_n  = 8'd0;
			ready_n  = 1'b0;
			ustart_n = 3'd0;
			ulen_n   = '0;
			ovf_n    = 1'b0;
			k_n      = 3'd0;
			case (action_q)
				atf_pkg::ACT_BYTE: begin
					if (cmd_mode_q) begin
						if (result_q == atf_pkg::RES_WAIT) begin
							if (echo_q) begin
								if (byte_q == atf_pkg::CH_LF && prior_q == atf_pkg::CH_CR) begin
									echo_n  = 1'b0;
									prior_n = 8'd0;
								end else begin
									prior_n = byte_q;
								end
							end else begin
								case (kind_q)
									atf_pkg::MK_LINE: begin
										pos_n  = 4'd1;
										kind_c = atf_pkg::first_kind(byte_q);
									end
									atf_pkg::MK_OK, atf_pkg::MK_ERROR, atf_pkg::MK_SEND: begin
										if (pos_q < tlen && atf_pkg::term_char(kind_q, pos_q) == byte_q) begin
											pos_n  = pos_q + 4'd1;
											kind_c = kind_q;
											if (pos_q + 4'd1 == tlen) begin
												matched  = 1'b1;
												result_n = (kind_q == atf_pkg::MK_ERROR) ?
													atf_pkg::RES_ERROR : atf_pkg::RES_OK;
												fill_n   = (fill_q > FW'(tlen)) ?
													fill_q - FW'(tlen) - FW'(1) : '0;
											end
										end
									end
									default: begin
										kind_c = atf_pkg::MK_NONE;
									end
								endcase
								prior_n = byte_q;
								if (!matched) begin
									if (byte_q == atf_pkg::CH_LF && prior_q == atf_pkg::CH_CR &&
										kind_c == atf_pkg::MK_NONE) begin
										kind_c = atf_pkg::MK_LINE;
									end
									kind_n   = kind_c;
									do_store = 1'b1;
								end
							end
						end
					end else if (elapsed_q <= gap_q) begin
						do_store = 1'b1;
						if (!full) begin
							elapsed_n = 16'd0;
						end
					end
					if (do_store) begin
						if (full) begin
							ovf_n = 1'b1;
						end else begin
							ram_we = 1'b1;
							fill_n = fill_q + FW'(1);
						end
					end
				end
				atf_pkg::ACT_TICK: begin
					if (cmd_mode_q) begin
						if (result_q != atf_pkg::RES_WAIT) begin
							fill_n     = '0;
							elapsed_n  = 16'd0;
							cmd_mode_n = 1'b0;
						end else begin
							elapsed_n = elapsed_inc;
							if (elapsed_inc > timeout_q) begin
								result_n = atf_pkg::RES_TIMEOUT;
							end
						end
					end else begin
						elapsed_n = elapsed_inc;
						if (elapsed_inc > gap_q) begin
							if (fill_q >= FW'(atf_pkg::URC_MIN_LEN)) begin
								stat.next = atf_pkg::NX_SCAN;
								ram_re    = 1'b1;
								ram_raddr = '0;
							end else begin
								fill_n    = '0;
								elapsed_n = 16'd0;
							end
						end
					end
				end
				atf_pkg::ACT_START: begin
					cmd_mode_n = 1'b1;
					echo_n     = 1'b1;
					fill_n     = '0;
					result_n   = atf_pkg::RES_WAIT;
					elapsed_n  = 16'd0;
					kind_n     = atf_pkg::MK_LINE;
					pos_n      = 4'd0;
					prior_n    = 8'd0;
				end
				atf_pkg::ACT_READ: begin
					if (idx_in_range) begin
						ram_re    = 1'b1;
						ram_raddr = AW'(idx_q);
						stat.next = atf_pkg::NX_READ;
					end
				end
				default: begin
					stat.next = atf_pkg::NX_DONE;
				end
			endcase
		end

		// one leading byte per cycle
		if (cmd.scan) begin
			if (ram_rdata == atf_pkg::CH_CR || ram_rdata == atf_pkg::CH_LF) begin
				if (k_q == atf_pkg::URC_MAX_SKIP) begin
					stat.scan_done = 1'b1;
					fill_n         = '0;
					elapsed_n      = 16'd0;
				end else begin
					k_n       = k_q + 3'd1;
					ram_re    = 1'b1;
					ram_raddr = AW'(k_q + 3'd1);
				end
			end else begin
				stat.scan_done = 1'b1;
				ready_n        = 1'b1;
				ustart_n       = k_q;
				ulen_n         = (fill_q >= k_ext + FW'(2)) ? fill_q - k_ext - FW'(2) : '0;
				fill_n         = '0;
				elapsed_n      = 16'd0;
			end
		end

		if (cmd.read_done) begin
			rdata_n = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			cmd_mode_q <= 1'b0;
			echo_q     <= 1'b0;
			kind_q     <= atf_pkg::MK_LINE;
			pos_q      <= 4'd0;
			prior_q    <= 8'd0;
			elapsed_q  <= 16'd0;
			result_q   <= atf_pkg::RES_WAIT;
			timeout_q  <= atf_pkg::TIMEOUT_RESET;
			gap_q      <= atf_pkg::GAP_RESET;
		end else begin
			fill_q     <= fill_n;
			cmd_mode_q <= cmd_mode_n;
			echo_q     <= echo_n;
			kind_q     <= kind_n;
			pos_q      <= pos_n;
			prior_q    <= prior_n;
			elapsed_q  <= elapsed_n;
			result_q   <= result_n;
			if (cfg_we) begin
				case (cfg_index)
					atf_pkg::CFG_RESPONSE_TIMEOUT: timeout_q <= cfg_data;
					atf_pkg::CFG_URC_GAP:          gap_q <= cfg_data;
					default:                       gap_q <= gap_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= atf_pkg::action_t'(action);
			byte_q   <= rx_byte;
			idx_q    <= read_index;
		end
		k_q      <= k_n;
		rdata_q  <= rdata_n;
		ready_q  <= ready_n;
		ustart_q <= ustart_n;
		ulen_q   <= ulen_n;
		ovf_q    <= ovf_n;
		if (cmd.load) begin
			status         <= result_q;
			payload_length <= 9'(fill_q);
			read_data      <= rdata_q;
			urc_ready      <= ready_q;
			urc_start      <= ustart_q;
			urc_length     <= 9'(ulen_q);
			overflow       <= ovf_q;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(atf_pkg::BUFFER_DEPTH))
		else $error("fill count beyond buffer depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && ovf_q) |-> (fill_q == FW'(atf_pkg::BUFFER_DEPTH)))
		else $error("byte dropped while buffer not full");

	a_urc_released: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && ready_q) |-> (!cmd_mode_q && fill_q == '0 && elapsed_q == 16'd0))
		else $error("framed message did not release the buffer");

endmodule
`default_nettype wire

FILE: sv/at_response_and_urc_framer_core.sv
// top level of the at response and unsolicited message framer
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------------
//  req      | in  | action, rx_byte, read_index
//  rsp      | out | status, payload_length, read_data, urc_*, overflow
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// one beat at a time: accept, execute, then load into the result register
// byte, start and plain tick beats load after execute; a buffer read adds a ram read wait
// a tick that frames a message reads up to eight leading bytes, one per cycle
// a stalled rsp holds the result register; req is taken again once it is handed over
// arst_n clears all control state; the line store ram has no reset and no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module at_response_and_urc_framer_core (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [atf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [atf_pkg::CFG_DATA_W-1:0]  cfg_data,
	atf_req_if.sink                        req,
	atf_rsp_if.source                      rsp
);

	atf_pkg::dp_cmd_t  cmd;
	atf_pkg::dp_stat_t stat;

	atf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	atf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.stat           (stat),
		.action         (req.action),
		.rx_byte        (req.rx_byte),
		.read_index     (req.read_index),
		.status         (rsp.status),
		.payload_length (rsp.payload_length),
		.read_data      (rsp.read_data),
		.urc_ready      (rsp.urc_ready),
		.urc_start      (rsp.urc_start),
		.urc_length     (rsp.urc_length),
		.overflow       (rsp.overflow)
	);

endmodule
`default_nettype wire
